FILE: rtl/ssd_pkg.sv
// Package: shared types, segment table and BCD conversion helper for the display encoder.
`timescale 1ns / 1ps

package ssd_pkg;

    localparam int VALUE_W     = 32;
    localparam int DIGIT_W     = 4;
    localparam int NUM_DIGITS  = 8;
    localparam int BCD_W       = NUM_DIGITS * DIGIT_W;
    localparam int SEG_W       = 8;
    localparam int STAGE_BITS  = 8;
    localparam int NUM_STAGES  = VALUE_W / STAGE_BITS;

    // Display mode carried in tuser.
    localparam logic KIND_HEX = 1'b0;
    localparam logic KIND_DEC = 1'b1;

    // Segment code per digit value 0..15.
    localparam logic [SEG_W-1:0] SEG_CODE [16] = '{
        8'h40, 8'hf9, 8'h24, 8'h30, 8'h99, 8'h92, 8'h82, 8'hf8,
        8'h00, 8'h10, 8'h08, 8'h83, 8'hc6, 8'he1, 8'h86, 8'h8e
    };

    // Payload moving down the conversion pipeline.
    typedef struct packed {
        logic               kind;
        logic [VALUE_W-1:0] raw;   // original value, used in hex mode
        logic [VALUE_W-1:0] rem;   // bits still to be shifted in, MSB first
        logic [BCD_W-1:0]   bcd;   // low eight BCD digits so far
    } t_stage;

    // One shift-and-add-3 step. Digits above the eighth are dropped, which
    // gives the value mod 10^8 since carries only move upward.
    function automatic logic [BCD_W-1:0] dabble_step(input logic [BCD_W-1:0] bcd,
                                                     input logic din);
        logic [BCD_W-1:0] adj;
        adj = bcd;
        for (int d = 0; d < NUM_DIGITS; d++) begin
            if (adj[d*DIGIT_W +: DIGIT_W] >= 4'd5) begin
                adj[d*DIGIT_W +: DIGIT_W] = adj[d*DIGIT_W +: DIGIT_W] + 4'd3;
            end
        end
        return {adj[BCD_W-2:0], din};
    endfunction

endpackage

FILE: rtl/ssd_dabble_stage.sv
// Module: one registered pipeline stage of the binary to BCD converter (eight bits per stage).
`timescale 1ns / 1ps

module ssd_dabble_stage (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  ssd_pkg::t_stage i_data,
    output logic           o_valid,
    input  logic           i_ready,
    output ssd_pkg::t_stage o_data
);

    logic            r_valid;
    ssd_pkg::t_stage r_data;
    ssd_pkg::t_stage n_data;

    // Shift the next eight value bits into the BCD accumulator.
    always_comb begin
        n_data = i_data;
        for (int k = 0; k < ssd_pkg::STAGE_BITS; k++) begin
            n_data.bcd = ssd_pkg::dabble_step(n_data.bcd, n_data.rem[ssd_pkg::VALUE_W-1]);
            n_data.rem = {n_data.rem[ssd_pkg::VALUE_W-2:0], 1'b0};
        end
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

FILE: rtl/seven_segment_display_encoder.sv
// Top level: 32-bit value to eight seven-segment codes, hex or decimal, fully pipelined.
`timescale 1ns / 1ps

//  Channel   Dir  Bits            Contents
//  s_axis    in   tdata[31:0]     value
//                 tuser[0]        kind (0 hex, 1 decimal)
//  m_axis    out  tdata[63:0]     left_pattern, right_pattern, quad_pattern
//
//  An input transaction passes through four conversion stages (eight
//  shift-and-add-3 steps each) and then the segment lookup register.
//  One transaction is accepted every cycle while the output is taken.
//  Reset (synchronous, active low) clears only the valid bits.
//  Each stage holds its item while the next is full and stalled; a bubble
//  is filled even during a stall, so nothing is dropped or duplicated.

module seven_segment_display_encoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] value
    input  logic        s_axis_tuser,   // [0] kind
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata    // [15:0] left, [31:16] right, [63:32] quad
);

    // Pipeline links: index 0 is the input, index NUM_STAGES the last converter stage.
    ssd_pkg::t_stage                    w_data  [ssd_pkg::NUM_STAGES+1];
    logic [ssd_pkg::NUM_STAGES:0]       w_valid;
    logic [ssd_pkg::NUM_STAGES:0]       w_ready;

    // Output register.
    logic                               r_out_valid;
    logic [63:0]                        r_out_data;
    logic [63:0]                        n_out_data;
    logic [ssd_pkg::BCD_W-1:0]          w_nibbles;

    assign w_valid[0]           = s_axis_tvalid;
    assign s_axis_tready        = w_ready[0];
    assign w_data[0].kind       = s_axis_tuser;
    assign w_data[0].raw        = s_axis_tdata;
    assign w_data[0].rem        = s_axis_tdata;
    assign w_data[0].bcd        = '0;

    for (genvar g = 0; g < ssd_pkg::NUM_STAGES; g++) begin : g_stage
        ssd_dabble_stage u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_valid[g]),
            .o_ready (w_ready[g]),
            .i_data  (w_data[g]),
            .o_valid (w_valid[g+1]),
            .i_ready (w_ready[g+1]),
            .o_data  (w_data[g+1])
        );
    end

    // Final stage: pick hex nibbles or decimal digits, then look up each code.
    assign w_ready[ssd_pkg::NUM_STAGES] = !r_out_valid || m_axis_tready;

    always_comb begin
        w_nibbles = (w_data[ssd_pkg::NUM_STAGES].kind == ssd_pkg::KIND_DEC) ?
                    w_data[ssd_pkg::NUM_STAGES].bcd :
                    w_data[ssd_pkg::NUM_STAGES].raw;
        // Digit 0 lands in the quad low byte, digit 7 in the left high byte.
        n_out_data[39:32] = ssd_pkg::SEG_CODE[w_nibbles[3:0]];
        n_out_data[47:40] = ssd_pkg::SEG_CODE[w_nibbles[7:4]];
        n_out_data[55:48] = ssd_pkg::SEG_CODE[w_nibbles[11:8]];
        n_out_data[63:56] = ssd_pkg::SEG_CODE[w_nibbles[15:12]];
        n_out_data[23:16] = ssd_pkg::SEG_CODE[w_nibbles[19:16]];
        n_out_data[31:24] = ssd_pkg::SEG_CODE[w_nibbles[23:20]];
        n_out_data[7:0]   = ssd_pkg::SEG_CODE[w_nibbles[27:24]];
        n_out_data[15:8]  = ssd_pkg::SEG_CODE[w_nibbles[31:28]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_ready[ssd_pkg::NUM_STAGES]) begin
            r_out_valid <= w_valid[ssd_pkg::NUM_STAGES];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ready[ssd_pkg::NUM_STAGES] && w_valid[ssd_pkg::NUM_STAGES]) begin
            r_out_data <= n_out_data;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule

FILE: sim/seven_segment_display_encoder_test.sv
// Testbench: streams hex and decimal values through the display encoder and checks every code.
`timescale 1ns / 1ps

module seven_segment_display_encoder_test;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int DRAIN_CYCLES  = 20;     // several times the pipeline latency
    localparam int RANDOM_BLOCKS = 10;
    localparam int BLOCK_ITEMS   = 113;

    // Segment codes per digit value, kept independently of the design.
    localparam logic [7:0] DIGIT_SEGMENTS [16] = '{
        8'h40, 8'hf9, 8'h24, 8'h30, 8'h99, 8'h92, 8'h82, 8'hf8,
        8'h00, 8'h10, 8'h08, 8'h83, 8'hc6, 8'he1, 8'h86, 8'h8e
    };

    typedef struct packed {
        logic [31:0] quad;
        logic [15:0] right;
        logic [15:0] left;
    } t_display;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;   // [31:0] value
    logic        s_axis_tuser;   // [0] kind
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [63:0] m_axis_tdata;   // [15:0] left, [31:16] right, [63:32] quad

    t_display    pending_displays [$];
    int          error_count  = 0;
    int          cycle_count  = 0;
    int          src_wait_max = 13;  // upper bound on idle cycles before each sent transaction
    int          sink_wait_max = 13; // upper bound on stall cycles after each taken transaction
    int          sink_stall   = 0;

    seven_segment_display_encoder DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #2 i_clk = ~i_clk;

    function automatic int draw_wait(input int max_wait);
        if (max_wait <= 0) begin
            return 0;
        end
        return $urandom_range(max_wait, 0);
    endfunction

    // Expected segment codes: hex nibbles as they are, or the low eight decimal digits.
    function automatic t_display encode_display(input logic kind, input logic [31:0] value);
        t_display    codes;
        logic [31:0] shown;
        logic [31:0] rem;
        logic [3:0]  digit [8];
        shown = value % 32'd100000000;
        for (int i = 0; i < 8; i++) begin
            if (kind == ssd_pkg::KIND_DEC) begin
                rem      = shown % 32'd10;
                digit[i] = rem[3:0];
                shown    = shown / 32'd10;
            end else begin
                digit[i] = value[4*i +: 4];
            end
        end
        codes.left  = {DIGIT_SEGMENTS[digit[7]], DIGIT_SEGMENTS[digit[6]]};
        codes.right = {DIGIT_SEGMENTS[digit[5]], DIGIT_SEGMENTS[digit[4]]};
        codes.quad  = {DIGIT_SEGMENTS[digit[3]], DIGIT_SEGMENTS[digit[2]],
                       DIGIT_SEGMENTS[digit[1]], DIGIT_SEGMENTS[digit[0]]};
        return codes;
    endfunction

    // One input transaction; returns in the time step of the accepting edge.
    task automatic send_value(input logic kind, input logic [31:0] value);
        int gap;
        gap = draw_wait(src_wait_max);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= value;
        do @(posedge i_clk); while (!s_axis_tready);
        pending_displays.push_back(encode_display(kind, value));
    endtask

    // Output side: random stalls after each result, compared against the oldest prediction.
    always @(posedge i_clk) begin
        t_display got;
        t_display want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            sink_stall = 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got = m_axis_tdata;
                if (pending_displays.size() == 0) begin
                    $error("unexpected result transaction: %h", m_axis_tdata);
                    error_count++;
                end else begin
                    want = pending_displays.pop_front();
                    if (got.left !== want.left) begin
                        $error("left_pattern: expected %h, got %h", want.left, got.left);
                        error_count++;
                    end
                    if (got.right !== want.right) begin
                        $error("right_pattern: expected %h, got %h", want.right, got.right);
                        error_count++;
                    end
                    if (got.quad !== want.quad) begin
                        $error("quad_pattern: expected %h, got %h", want.quad, got.quad);
                        error_count++;
                    end
                end
                sink_stall = draw_wait(sink_wait_max);
            end else if (sink_stall > 0) begin
                sink_stall--;
            end
            m_axis_tready <= (sink_stall == 0);
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic test_hex_extremes();
        send_value(ssd_pkg::KIND_HEX, 32'h0000_0000);
        send_value(ssd_pkg::KIND_HEX, 32'hffff_ffff);
        send_value(ssd_pkg::KIND_HEX, 32'h0123_4567);
        send_value(ssd_pkg::KIND_HEX, 32'h89ab_cdef);
        send_value(ssd_pkg::KIND_HEX, 32'hfedc_ba98);
        send_value(ssd_pkg::KIND_HEX, 32'h8000_0000);
        send_value(ssd_pkg::KIND_HEX, 32'h0000_0001);
        send_value(ssd_pkg::KIND_HEX, 32'h5a5a_a5a5);
        send_value(ssd_pkg::KIND_HEX, 32'h8d9a_d8a9);  // digits 8, 9, a and d
    endtask

    task automatic test_decimal_extremes();
        send_value(ssd_pkg::KIND_DEC, 32'd0);
        send_value(ssd_pkg::KIND_DEC, 32'd99999999);
        send_value(ssd_pkg::KIND_DEC, 32'd100000000);   // ninth digit dropped
        send_value(ssd_pkg::KIND_DEC, 32'd100000001);
        send_value(ssd_pkg::KIND_DEC, 32'hffff_ffff);   // 4294967295 shows 94967295
        send_value(ssd_pkg::KIND_DEC, 32'd12345678);
        send_value(ssd_pkg::KIND_DEC, 32'd87654321);
        send_value(ssd_pkg::KIND_DEC, 32'd89898989);
        send_value(ssd_pkg::KIND_DEC, 32'd1000000);     // boundary of the upper pair
        send_value(ssd_pkg::KIND_DEC, 32'd10000);       // boundary of the middle pair
        send_value(ssd_pkg::KIND_DEC, 32'd9999);
        send_value(ssd_pkg::KIND_DEC, 32'd7);
    endtask

    // Mixed random traffic; each block runs under its own idling profile.
    task automatic test_random_mix();
        int          src_profile  [RANDOM_BLOCKS] = '{13, 0, 13, 0, 3, 13, 1, 0, 6, 13};
        int          sink_profile [RANDOM_BLOCKS] = '{13, 0, 0, 13, 3, 1, 13, 2, 6, 13};
        logic        kind;
        logic [31:0] value;
        logic [31:0] decade;
        for (int b = 0; b < RANDOM_BLOCKS; b++) begin
            src_wait_max  = src_profile[b];
            sink_wait_max = sink_profile[b];
            for (int n = 0; n < BLOCK_ITEMS; n++) begin
                kind = 1'($urandom_range(1, 0));
                case ($urandom_range(9, 0))
                    0, 1, 2, 3: value = $urandom;
                    4, 5: value = $urandom_range(99999999, 0);
                    6: value = $urandom_range(9999, 0);
                    7: begin
                        // around a power of ten, where digits roll over
                        decade = 32'd1;
                        repeat ($urandom_range(9, 0)) decade = decade * 32'd10;
                        value = decade + $urandom_range(2, 0) - 32'd1;
                    end
                    8: value = 32'd100000000 * $urandom_range(41, 0) + $urandom_range(99999999, 0);
                    default: value = ~32'd0 - $urandom_range(1000, 0);
                endcase
                send_value(kind, value);
            end
        end
    endtask

    initial begin
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tuser  <= ssd_pkg::KIND_HEX;
        s_axis_tdata  <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_hex_extremes();
        test_decimal_extremes();
        test_random_mix();

        s_axis_tvalid <= 1'b0;
        while (pending_displays.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (pending_displays.size() != 0) begin
            $error("%0d results never arrived", pending_displays.size());
            error_count++;
        end

        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
